### hdl/cosine_trajectory_pd_controller_assert.svh
// ----------------------------------------------------------------------------
// cosine trajectory pd controller assertion macros
// concurrent checks on the clk edge, masked while arst_n is low
// ----------------------------------------------------------------------------
`ifndef COSINE_TRAJECTORY_PD_CONTROLLER_ASSERT_SVH
`define COSINE_TRAJECTORY_PD_CONTROLLER_ASSERT_SVH

// consequent checked in the same cycle
`define CTPD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define CTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ctpd_pkg.sv
// ----------------------------------------------------------------------------
// ctpd_pkg
// types, widths, codes and the quarter-sine table of the move controller
// ----------------------------------------------------------------------------
`default_nettype none

package ctpd_pkg;

	localparam int TICKS_PER_SECOND = 500;
	localparam int PHASE_BITS       = 10;

	// pi in q28 times the tick rate, divided by twice the duration per move
	localparam longint unsigned RATE_NUM = 64'd843314857 * 64'(TICKS_PER_SECOND);
	localparam int RATE_W = $clog2(RATE_NUM + 64'd1);

	localparam int DIV_W   = (RATE_W > 16 + PHASE_BITS) ? RATE_W : 16 + PHASE_BITS;
	localparam int DEN_W   = 17;
	localparam int CHUNK_W = 16;
	localparam int NCH     = (((RATE_W > 32) ? RATE_W : 32) + CHUNK_W - 1) / CHUNK_W;
	localparam int B_W     = NCH * CHUNK_W;
	localparam int MA_W    = 34;
	localparam int ACC_W   = MA_W + B_W;
	localparam int PROD_W  = MA_W + CHUNK_W + 1;

	localparam logic [PHASE_BITS:0] PH_HALF = (PHASE_BITS + 1)'(1) << (PHASE_BITS - 1);
	localparam logic [PHASE_BITS:0] PH_FULL = (PHASE_BITS + 1)'(1) << PHASE_BITS;

	localparam logic [16:0] ELAPSED_MAX = 17'h1ffff;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	localparam logic [2:0] REG_KP1 = 3'd0;
	localparam logic [2:0] REG_KP2 = 3'd1;
	localparam logic [2:0] REG_KP3 = 3'd2;
	localparam logic [2:0] REG_KD1 = 3'd3;
	localparam logic [2:0] REG_KD2 = 3'd4;
	localparam logic [2:0] REG_KD3 = 3'd5;
	localparam logic [2:0] REG_DUR = 3'd6;

	localparam logic [16:0] QSIN [33] = '{
		17'd0,     17'd3216,  17'd6424,  17'd9616,  17'd12785, 17'd15924, 17'd19024,
		17'd22078, 17'd25080, 17'd28020, 17'd30893, 17'd33692, 17'd36410, 17'd39040,
		17'd41575, 17'd44011, 17'd46341, 17'd48559, 17'd50660, 17'd52639, 17'd54491,
		17'd56212, 17'd57798, 17'd59244, 17'd60547, 17'd61705, 17'd62714, 17'd63572,
		17'd64277, 17'd64827, 17'd65220, 17'd65457, 17'd65536
	};

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] pos_joint1;
		logic signed [31:0] pos_joint2;
		logic signed [31:0] pos_joint3;
		logic signed [31:0] vel_joint1;
		logic signed [31:0] vel_joint2;
		logic signed [31:0] vel_joint3;
		logic signed [31:0] goal_joint1;
		logic signed [31:0] goal_joint2;
		logic signed [31:0] goal_joint3;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] effort_joint1;
		logic signed [31:0] effort_joint2;
		logic signed [31:0] effort_joint3;
		logic signed [31:0] ref_pos_joint1;
		logic signed [31:0] ref_pos_joint2;
		logic signed [31:0] ref_pos_joint3;
		logic signed [31:0] ref_vel_joint1;
		logic signed [31:0] ref_vel_joint2;
		logic signed [31:0] ref_vel_joint3;
		logic               moving;
	} res_t;

	typedef struct packed {
		logic                   start;
		logic signed [MA_W-1:0] a;
		logic [B_W-1:0]         b;
	} mac_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W-1:0] acc;
	} mac_sts_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_sts_t;

	// q16 sine over a quarter turn, linear between table points, floored
	function automatic logic [16:0] qlookup(input logic [PHASE_BITS-1:0] u);
		logic [13:0] v;
		logic [5:0]  idx;
		logic [7:0]  fr;
		logic [16:0] lo;
		logic [16:0] hi;
		logic [19:0] d;
		v   = 14'(u) << (14 - PHASE_BITS);
		idx = v[13:8];
		fr  = v[7:0];
		if (idx >= 6'd32) begin
			return 17'd65536;
		end else begin
			lo = QSIN[idx];
			hi = QSIN[idx + 6'd1];
			d  = 20'(hi - lo) * 20'(fr);
			return lo + 17'(d >> 8);
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff})) begin
			return 32'sh7fffffff;
		end else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h80000000})) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

`default_nettype wire

### hdl/ctpd_div.sv
// ----------------------------------------------------------------------------
// ctpd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ctpd_div import ctpd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_sts_t      sts
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W+1:0] trial;

	assign trial = {1'b0, rem_q, num_q[DIV_W-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			// remainder always stays below the divisor
			if (!trial[DEN_W+1]) begin
				rem_q <= trial[DEN_W-1:0];
				num_q <= {num_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DEN_W-2:0], num_q[DIV_W-1]};
				num_q <= {num_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign sts.quo  = num_q;

endmodule

`default_nettype wire

### hdl/ctpd_mac.sv
// ----------------------------------------------------------------------------
// ctpd_mac
// shared signed by unsigned multiplier, one 16-bit chunk of b per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ctpd_mac import ctpd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mac_req_t req,
	output mac_sts_t      sts
);

	localparam int CNT_W = $clog2(NCH + 1);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [MA_W-1:0]   a_q;
	logic [B_W-1:0]           b_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod;

	assign prod = a_q * $signed({1'b0, b_q[B_W-1 -: CHUNK_W]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NCH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	// horner over chunks, most significant chunk first
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< CHUNK_W) + ACC_W'(prod);
			b_q   <= b_q << CHUNK_W;
		end
	end

	assign sts.done = done_q;
	assign sts.acc  = acc_q;

endmodule

`default_nettype wire

### hdl/cosine_trajectory_pd_controller.sv
// ----------------------------------------------------------------------------
// cosine_trajectory_pd_controller
// three-joint pd move controller on a half-cosine reference trajectory
// ----------------------------------------------------------------------------
//  channel  | signals                          | role
//  cmd      | cmd_valid, cmd_stall, cmd        | request in: tick, start or stop
//  res      | res_valid, res_stall, res        | efforts, references, moving
//  cfg      | cfg_we, cfg_index, cfg_data      | gain and duration writes
//
//  a moving tick or a start runs two serial divides for phase and rate,
//  then five chunked multiplies per joint on the one shared multiplier.
//  zero duration skips the divides and the first three multiplies; stop,
//  idle tick and unused modes do no arithmetic and go straight to the
//  output. cmd_stall is high while an item is worked on; the result waits
//  in an output register, and the next request is taken while it waits.
//  control state, gains, duration and held references and efforts clear on arst_n; datapath and result data do not.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_trajectory_pd_controller import ctpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire cmd_t        cmd,
	output logic             res_valid,
	input  wire logic        res_stall,
	output res_t             res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_DIVP = 10'b0000000010,
		S_DIVR = 10'b0000000100,
		S_LUT  = 10'b0000001000,
		S_JUMP = 10'b0000010000,
		S_MPOS = 10'b0000100000,
		S_MA   = 10'b0001000000,
		S_MV   = 10'b0010000000,
		S_MKP  = 10'b0100000000,
		S_MKD  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic   go_q;
	logic   out_pend_q;
	logic   res_valid_q;
	res_t   res_q;

	logic [31:0] kp_q [3];
	logic [31:0] kd_q [3];
	logic [15:0] dur_q;

	logic               active_q;
	logic [16:0]        elapsed_q;
	logic [1:0]         j_q;
	logic signed [31:0] start_q [3];
	logic signed [31:0] tgt_q   [3];
	logic signed [31:0] hpos_q  [3];
	logic signed [31:0] hvel_q  [3];
	logic signed [31:0] heff_q  [3];
	logic signed [31:0] pos_q   [3];
	logic signed [31:0] vel_q   [3];

	logic [PHASE_BITS:0]      p_q;
	logic [RATE_W-1:0]        rate_q;
	logic [16:0]              s_q;
	logic signed [17:0]       c_q;
	logic signed [MA_W-1:0]   a_q;
	logic signed [ACC_W-17:0] e1_q;

	logic [16:0]              s_c;
	logic signed [17:0]       c_c;
	logic [15:0]              tc;
	logic signed [18:0]       omc;
	logic signed [ACC_W-1:0]  acc_sh16;
	logic signed [ACC_W-1:0]  acc_sh17;
	logic signed [ACC_W-1:0]  acc_sh28;
	logic                     take;
	logic                     compute;
	logic [1:0]               mode;

	mac_req_t mac_req;
	mac_sts_t mac_sts;
	div_req_t div_req;
	div_sts_t div_sts;

	ctpd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.sts    (mac_sts)
	);

	ctpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	assign take    = cmd_valid && (state_q == S_IDLE) && !out_pend_q;
	assign mode    = cmd.mode;
	assign compute = (mode == MODE_START) || ((mode == MODE_TICK) && active_q);

	assign tc  = (elapsed_q < {1'b0, dur_q}) ? elapsed_q[15:0] : dur_q;
	assign omc = 19'sd65536 - 19'(c_q);

	assign acc_sh16 = mac_sts.acc >>> 16;
	assign acc_sh17 = mac_sts.acc >>> 17;
	assign acc_sh28 = mac_sts.acc >>> 28;

	// sine and cosine of the phase, second quarter mirrored
	always_comb begin
		if (p_q <= PH_HALF) begin
			s_c = qlookup(PHASE_BITS'(p_q));
			c_c = 18'(qlookup(PHASE_BITS'(PH_HALF - p_q)));
		end else begin
			s_c = qlookup(PHASE_BITS'(PH_FULL - p_q));
			c_c = -18'(qlookup(PHASE_BITS'(p_q - PH_HALF)));
		end
	end

	always_comb begin
		div_req.start = go_q && ((state_q == S_DIVP) || (state_q == S_DIVR));
		if (state_q == S_DIVP) begin
			div_req.num = DIV_W'({tc, {PHASE_BITS{1'b0}}});
			div_req.den = {1'b0, dur_q};
		end else begin
			div_req.num = DIV_W'(RATE_NUM);
			div_req.den = {dur_q, 1'b0};
		end
	end

	always_comb begin
		mac_req.start = go_q && ((state_q == S_MPOS) || (state_q == S_MA) ||
			(state_q == S_MV) || (state_q == S_MKP) || (state_q == S_MKD));
		case (state_q)
			S_MPOS: begin
				mac_req.a = MA_W'(tgt_q[j_q]) - MA_W'(start_q[j_q]);
				mac_req.b = B_W'(omc[17:0]);
			end
			S_MA: begin
				mac_req.a = MA_W'(tgt_q[j_q]) - MA_W'(start_q[j_q]);
				mac_req.b = B_W'(s_q);
			end
			S_MV: begin
				mac_req.a = a_q;
				mac_req.b = B_W'(rate_q);
			end
			S_MKP: begin
				mac_req.a = MA_W'(hpos_q[j_q]) - MA_W'(pos_q[j_q]);
				mac_req.b = B_W'(kp_q[j_q]);
			end
			default: begin
				mac_req.a = MA_W'(hvel_q[j_q]) - MA_W'(vel_q[j_q]);
				mac_req.b = B_W'(kd_q[j_q]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= '{default: '0};
			kd_q  <= '{default: '0};
			dur_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KP1: kp_q[0] <= cfg_data;
				REG_KP2: kp_q[1] <= cfg_data;
				REG_KP3: kp_q[2] <= cfg_data;
				REG_KD1: kd_q[0] <= cfg_data;
				REG_KD2: kd_q[1] <= cfg_data;
				REG_KD3: kd_q[2] <= cfg_data;
				REG_DUR: dur_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			go_q       <= 1'b0;
			out_pend_q <= 1'b0;
			active_q   <= 1'b0;
			elapsed_q  <= '0;
			j_q        <= '0;
			start_q    <= '{default: '0};
			tgt_q      <= '{default: '0};
			hpos_q     <= '{default: '0};
			hvel_q     <= '{default: '0};
			heff_q     <= '{default: '0};
		end else begin
			if (out_pend_q && (!res_valid_q || !res_stall)) out_pend_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (mode == MODE_START) begin
							start_q   <= '{cmd.pos_joint1, cmd.pos_joint2, cmd.pos_joint3};
							tgt_q     <= '{cmd.goal_joint1, cmd.goal_joint2,
								cmd.goal_joint3};
							elapsed_q <= '0;
							active_q  <= 1'b1;
						end else if ((mode == MODE_TICK) && active_q &&
							(elapsed_q != ELAPSED_MAX)) begin
							elapsed_q <= elapsed_q + 17'd1;
						end
						if (mode == MODE_STOP) begin
							active_q <= 1'b0;
							heff_q   <= '{default: '0};
						end
						if (compute) begin
							go_q    <= 1'b1;
							state_q <= (dur_q == '0) ? S_JUMP : S_DIVP;
						end else begin
							out_pend_q <= 1'b1;
						end
					end
				end
				S_DIVP: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (div_sts.done) begin
						p_q     <= div_sts.quo[PHASE_BITS:0];
						go_q    <= 1'b1;
						state_q <= S_DIVR;
					end
				end
				S_DIVR: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (div_sts.done) begin
						rate_q  <= div_sts.quo[RATE_W-1:0];
						state_q <= S_LUT;
					end
				end
				S_LUT: begin
					s_q     <= s_c;
					c_q     <= c_c;
					j_q     <= '0;
					go_q    <= 1'b1;
					state_q <= S_MPOS;
				end
				S_JUMP: begin
					// zero duration lands on the target with zero velocity
					hpos_q  <= tgt_q;
					hvel_q  <= '{default: '0};
					j_q     <= '0;
					go_q    <= 1'b1;
					state_q <= S_MKP;
				end
				S_MPOS: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mac_sts.done) begin
						hpos_q[j_q] <= start_q[j_q] + acc_sh17[31:0];
						go_q        <= 1'b1;
						state_q     <= S_MA;
					end
				end
				S_MA: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mac_sts.done) begin
						a_q     <= acc_sh16[MA_W-1:0];
						go_q    <= 1'b1;
						state_q <= S_MV;
					end
				end
				S_MV: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mac_sts.done) begin
						hvel_q[j_q] <= sat32(acc_sh28);
						go_q        <= 1'b1;
						state_q     <= S_MKP;
					end
				end
				S_MKP: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mac_sts.done) begin
						e1_q    <= acc_sh16[ACC_W-17:0];
						go_q    <= 1'b1;
						state_q <= S_MKD;
					end
				end
				S_MKD: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mac_sts.done) begin
						heff_q[j_q] <= sat32(ACC_W'(e1_q) + acc_sh16);
						if (j_q == 2'd2) begin
							if (elapsed_q > {1'b0, dur_q}) active_q <= 1'b0;
							out_pend_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							j_q     <= j_q + 2'd1;
							go_q    <= 1'b1;
							state_q <= (dur_q == '0) ? S_MKP : S_MPOS;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_q <= '{cmd.pos_joint1, cmd.pos_joint2, cmd.pos_joint3};
			vel_q <= '{cmd.vel_joint1, cmd.vel_joint2, cmd.vel_joint3};
		end
	end

	// result register, loaded once the previous result has gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_pend_q && (!res_valid_q || !res_stall)) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_pend_q && (!res_valid_q || !res_stall)) begin
			res_q.effort_joint1  <= heff_q[0];
			res_q.effort_joint2  <= heff_q[1];
			res_q.effort_joint3  <= heff_q[2];
			res_q.ref_pos_joint1 <= hpos_q[0];
			res_q.ref_pos_joint2 <= hpos_q[1];
			res_q.ref_pos_joint3 <= hpos_q[2];
			res_q.ref_vel_joint1 <= hvel_q[0];
			res_q.ref_vel_joint2 <= hvel_q[1];
			res_q.ref_vel_joint3 <= hvel_q[2];
			res_q.moving         <= active_q;
		end
	end

	assign cmd_stall = (state_q != S_IDLE) || out_pend_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### hdl/ctpd_checker.sv
// ----------------------------------------------------------------------------
// ctpd_checker
// port-level checks of the move controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "cosine_trajectory_pd_controller_assert.svh"

module ctpd_checker import ctpd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_stall,
	input wire cmd_t cmd,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire res_t res
);

	`CTPD_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result moved")
	`CTPD_ASSERT_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(cmd), "request moved")
	`CTPD_ASSERT_NEXT(a_busy_after_take, cmd_valid && !cmd_stall, cmd_stall, "took a second request")
	`CTPD_ASSERT_SAME(a_res_from_work, $rose(res_valid), $past(cmd_stall), "result without request")

endmodule

bind cosine_trajectory_pd_controller ctpd_checker u_ctpd_checker (.*);

`default_nettype wire

### dv/tb_cosine_trajectory_pd_controller.sv
// ----------------------------------------------------------------------------
// tb_cosine_trajectory_pd_controller
// drives ticks, starts and stops through several gain and duration settings,
// predicts the efforts and reference trajectory in q16.16 and checks each
// result in order under random request idling and result back-pressure
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cosine_trajectory_pd_controller;
	import ctpd_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam longint unsigned PI_RATE = 64'd843314857 * 64'd500;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_KP1;
	logic [31:0] cfg_data = '0;

	cosine_trajectory_pd_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	cmd_t pending_cmds[$];
	res_t expected_res[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int long_hold = 0;
	logic took = 1'b0;
	int errors = 0;
	int n_cmds = 0;
	int n_res = 0;
	int n_moves = 0;
	int cycles = 0;

	// predictor copy of gains, duration and move state
	logic [31:0] kp_g[3];
	logic [31:0] kd_g[3];
	logic [15:0] dur_g;
	logic in_move;
	logic [16:0] ticks_done;
	logic signed [31:0] start_pt[3];
	logic signed [31:0] target_pt[3];
	logic signed [31:0] held_eff[3];
	logic signed [31:0] held_rp[3];
	logic signed [31:0] held_rv[3];

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sh7fffffff) return 32'sh7fffffff;
		if (v < -128'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic int sine_q16(input int u);
		int v;
		int idx;
		int fr;
		v = u << 4;
		idx = v >> 8;
		fr = v & 255;
		if (idx >= 32) return 65536;
		return int'(QSIN[idx]) + (((int'(QSIN[idx + 1]) - int'(QSIN[idx])) * fr) >> 8);
	endfunction

	task automatic track_joint(input int j, input logic signed [31:0] pos,
		input logic signed [31:0] vel);
		logic signed [127:0] rp;
		logic signed [127:0] rv;
		logic signed [127:0] delta;
		logic signed [127:0] a;
		logic signed [127:0] rate;
		logic signed [127:0] kpw;
		logic signed [127:0] kdw;
		int tc;
		int p;
		int s;
		int c;
		if (dur_g == 0) begin
			rp = target_pt[j];
			rv = 0;
		end else begin
			tc = (ticks_done < dur_g) ? int'(ticks_done) : int'(dur_g);
			p = (tc << 10) / int'(dur_g);
			if (p <= 512) begin
				s = sine_q16(p);
				c = sine_q16(512 - p);
			end else begin
				s = sine_q16(1024 - p);
				c = -sine_q16(p - 512);
			end
			delta = 128'(target_pt[j]) - 128'(start_pt[j]);
			rp = 128'(start_pt[j]) + ((delta * 128'(65536 - c)) >>> 17);
			a = (delta * 128'(s)) >>> 16;
			rate = $signed(128'(PI_RATE / (64'd2 * 64'(dur_g))));
			rv = clamp32((a * rate) >>> 28);
		end
		kpw = $signed({96'b0, kp_g[j]});
		kdw = $signed({96'b0, kd_g[j]});
		held_rp[j] = rp[31:0];
		held_rv[j] = rv[31:0];
		held_eff[j] = clamp32((((rp - 128'(pos)) * kpw) >>> 16)
			+ (((rv - 128'(vel)) * kdw) >>> 16));
	endtask

	task automatic predict_controller(input cmd_t c, output res_t r);
		logic signed [31:0] pos[3];
		logic signed [31:0] vel[3];
		logic signed [31:0] goal[3];
		logic run;
		pos = '{c.pos_joint1, c.pos_joint2, c.pos_joint3};
		vel = '{c.vel_joint1, c.vel_joint2, c.vel_joint3};
		goal = '{c.goal_joint1, c.goal_joint2, c.goal_joint3};
		run = 1'b0;
		if (c.mode == MODE_START) begin
			for (int j = 0; j < 3; j++) begin
				start_pt[j] = pos[j];
				target_pt[j] = goal[j];
			end
			ticks_done = '0;
			in_move = 1'b1;
			run = 1'b1;
		end else if (c.mode == MODE_STOP) begin
			in_move = 1'b0;
			for (int j = 0; j < 3; j++) held_eff[j] = '0;
		end else if (c.mode == MODE_TICK && in_move) begin
			if (ticks_done < ELAPSED_MAX) ticks_done++;
			run = 1'b1;
		end
		if (run) begin
			for (int j = 0; j < 3; j++) track_joint(j, pos[j], vel[j]);
			if (ticks_done > 17'(dur_g)) in_move = 1'b0;
		end
		r.effort_joint1 = held_eff[0];
		r.effort_joint2 = held_eff[1];
		r.effort_joint3 = held_eff[2];
		r.ref_pos_joint1 = held_rp[0];
		r.ref_pos_joint2 = held_rp[1];
		r.ref_pos_joint3 = held_rp[2];
		r.ref_vel_joint1 = held_rv[0];
		r.ref_vel_joint2 = held_rv[1];
		r.ref_vel_joint3 = held_rv[2];
		r.moving = in_move;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("mismatch %s at result %0d: got %h expected %h", what, n_res, got, want);
	endtask

	// accept side and checker, both on the rising edge
	always @(posedge clk) begin
		res_t want;
		res_t r;
		cycles++;
		took <= cmd_valid && !cmd_stall;
		if (arst_n && cmd_valid && !cmd_stall) begin
			predict_controller(cmd, r);
			expected_res.push_back(r);
			n_cmds++;
			if (cmd.mode == MODE_START) n_moves++;
		end
		if (arst_n && res_valid && !res_stall) begin
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected result", '0, '0);
			end else begin
				want = expected_res.pop_front();
				if (res.effort_joint1 !== want.effort_joint1)
					report_mismatch("effort_joint1", res.effort_joint1, want.effort_joint1);
				if (res.effort_joint2 !== want.effort_joint2)
					report_mismatch("effort_joint2", res.effort_joint2, want.effort_joint2);
				if (res.effort_joint3 !== want.effort_joint3)
					report_mismatch("effort_joint3", res.effort_joint3, want.effort_joint3);
				if (res.ref_pos_joint1 !== want.ref_pos_joint1)
					report_mismatch("ref_pos_joint1", res.ref_pos_joint1, want.ref_pos_joint1);
				if (res.ref_pos_joint2 !== want.ref_pos_joint2)
					report_mismatch("ref_pos_joint2", res.ref_pos_joint2, want.ref_pos_joint2);
				if (res.ref_pos_joint3 !== want.ref_pos_joint3)
					report_mismatch("ref_pos_joint3", res.ref_pos_joint3, want.ref_pos_joint3);
				if (res.ref_vel_joint1 !== want.ref_vel_joint1)
					report_mismatch("ref_vel_joint1", res.ref_vel_joint1, want.ref_vel_joint1);
				if (res.ref_vel_joint2 !== want.ref_vel_joint2)
					report_mismatch("ref_vel_joint2", res.ref_vel_joint2, want.ref_vel_joint2);
				if (res.ref_vel_joint3 !== want.ref_vel_joint3)
					report_mismatch("ref_vel_joint3", res.ref_vel_joint3, want.ref_vel_joint3);
				if (res.moving !== want.moving)
					report_mismatch("moving", 32'(res.moving), 32'(want.moving));
			end
			n_res++;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || took)) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result receiver, with an optional long hold-off
	always @(negedge clk) begin
		if (long_hold > 0) begin
			long_hold <= long_hold - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(32'h000fffff);
			3: return -$urandom_range(32'h000fffff);
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t make_cmd(input logic [1:0] m);
		cmd_t c;
		c.mode = m;
		c.pos_joint1 = pick_value();
		c.pos_joint2 = pick_value();
		c.pos_joint3 = pick_value();
		c.vel_joint1 = pick_value();
		c.vel_joint2 = pick_value();
		c.vel_joint3 = pick_value();
		c.goal_joint1 = pick_value();
		c.goal_joint2 = pick_value();
		c.goal_joint3 = pick_value();
		return c;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DUR) dur_g = val[15:0];
		else if (idx < REG_KD1) kp_g[idx] = val;
		else kd_g[idx - REG_KD1] = val;
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(3))
			0: return 32'hffffffff;
			1: return 32'h0;
			2: return $urandom_range(32'h00040000);
			default: return $urandom;
		endcase
	endfunction

	task automatic drain();
		wait (pending_cmds.size() == 0 && !cmd_valid && expected_res.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		cmd_t c;
		int span;
		logic [15:0] dur;
		in_move = 1'b0;
		ticks_done = '0;
		dur_g = '0;
		for (int j = 0; j < 3; j++) begin
			kp_g[j] = '0; kd_g[j] = '0;
			start_pt[j] = '0; target_pt[j] = '0;
			held_eff[j] = '0; held_rp[j] = '0; held_rv[j] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: dur = 16'd4;
				1: dur = 16'd0;
				2: dur = 16'hffff;
				3: dur = 16'd1;
				default: dur = 16'($urandom_range(24, 2));
			endcase
			for (int j = 0; j < 3; j++) begin
				write_reg(REG_KP1 + 3'(j), (ph == 0) ? 32'h00010000 :
					(ph == 1) ? 32'hffffffff : pick_gain());
				write_reg(REG_KD1 + 3'(j), (ph == 0) ? 32'h00008000 :
					(ph == 1) ? 32'hffffffff : pick_gain());
			end
			write_reg(REG_DUR, 32'(dur));
			send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 69 : 0;
			recv_idle_pct = (ph < 2) ? 69 : (ph < 4) ? 34 : 0;

			if (ph == 0) begin
				// tick and spare mode while idle, then full-scale moves
				pending_cmds.push_back(make_cmd(MODE_TICK));
				pending_cmds.push_back(make_cmd(MODE_SPARE));
				c = make_cmd(MODE_START);
				c.pos_joint1 = 32'h7fffffff; c.goal_joint1 = 32'h80000000;
				c.pos_joint2 = 32'h80000000; c.goal_joint2 = 32'h7fffffff;
				c.pos_joint3 = 32'h0;        c.goal_joint3 = 32'h0;
				c.vel_joint1 = 32'h80000000; c.vel_joint2 = 32'h7fffffff;
				pending_cmds.push_back(c);
				repeat (6) pending_cmds.push_back(make_cmd(MODE_TICK));
				pending_cmds.push_back(make_cmd(MODE_START));
				pending_cmds.push_back(make_cmd(MODE_TICK));
				pending_cmds.push_back(make_cmd(MODE_SPARE));
				pending_cmds.push_back(make_cmd(MODE_STOP));
				pending_cmds.push_back(make_cmd(MODE_TICK));
				pending_cmds.push_back(make_cmd(MODE_STOP));
			end
			if (ph == 4) long_hold = 3000;

			while (pending_cmds.size() < 160) begin
				case ($urandom_range(9))
					7: pending_cmds.push_back(make_cmd(MODE_STOP));
					8: pending_cmds.push_back(make_cmd(MODE_SPARE));
					9: pending_cmds.push_back(make_cmd(2'($urandom_range(3))));
					default: begin
						span = (dur > 28) ? $urandom_range(30) : $urandom_range(dur + 2);
						pending_cmds.push_back(make_cmd(MODE_START));
						repeat (span) pending_cmds.push_back(make_cmd(MODE_TICK));
					end
				endcase
			end
			// sender stays quiet until every result of this phase is in
			drain();
		end

		$display("covered %0d requests, %0d moves, %0d results over 5 gain and duration settings",
			n_cmds, n_moves, n_res);
		$display("durations 0, 1, 4, 65535 and random, with idling and a long result hold-off");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

### cosine_trajectory_pd_controller.f
+incdir+hdl
hdl/ctpd_pkg.sv
hdl/ctpd_div.sv
hdl/ctpd_mac.sv
hdl/cosine_trajectory_pd_controller.sv
hdl/ctpd_checker.sv
dv/tb_cosine_trajectory_pd_controller.sv
